[design/tea_pkg.sv]
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants for the tilted ellipse arc vertex pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned FULL_TURN    = 360;
    localparam int unsigned HALF_TURN    = 180;
    localparam int unsigned QUARTER_TURN = 90;
    localparam int unsigned ANGLE_OFFSET = 720;
    localparam int unsigned BHASKARA_K   = 40500;
    localparam int unsigned RECIP_SHIFT  = 24;
    localparam int unsigned RECIP_360    = 46603;  // floor(2^24 / 360)

    // Per-vertex fields that ride alongside the angle and sine work
    typedef struct packed {
        logic [11:0] center_x;
        logic [11:0] center_y;
        logic [9:0]  radius_x;
        logic [9:0]  radius_y;
        logic [23:0] start_color;
        logic [23:0] end_color;
        logic [22:0] lerp_t;
        logic [7:0]  opacity;
        logic        path_start;
        logic        visible;
    } carry_t;

    // Sine and cosine of the vertex angle and of the tilt, signed Q1.16
    typedef struct packed {
        logic signed [17:0] sin_deg;
        logic signed [17:0] cos_deg;
        logic signed [17:0] sin_tilt;
        logic signed [17:0] cos_tilt;
    } trig_t;

endpackage

[design/tea_angle.sv]
// ----------------------------------------------------------------------------
// tea_angle
// Five-stage front end: wraps the vertex angle and tilt, forms lerp factor and
// opacity; divides by reciprocal multiplication with a single correction step.
// ----------------------------------------------------------------------------
module tea_angle #(
    parameter int STEPS = 90
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [11:0]          center_x,
    input  logic [11:0]          center_y,
    input  logic [9:0]           radius_x,
    input  logic [9:0]           radius_y,
    input  logic signed [9:0]    tilt_degrees,
    input  logic [8:0]           head_angle,
    input  logic [8:0]           trail_span,
    input  logic [7:0]           ring_opacity,
    input  logic [6:0]           vertex_index,
    input  logic [23:0]          start_color,
    input  logic [23:0]          end_color,
    output logic                 out_valid,
    output logic [8:0]           out_w_deg,
    output logic [8:0]           out_w_tilt,
    output tea_pkg::carry_t      out_carry
);
    import tea_pkg::*;

    localparam logic [7:0]  STEPS_C = 8'(STEPS);
    localparam logic [24:0] RECIP   = 25'((32'd1 << RECIP_SHIFT) / STEPS);

    // Stage 1: products and tilt wrap
    logic        v1_reg;
    logic [15:0] prod_a1_reg, prod_a_next;
    logic [14:0] prod_o1_reg, prod_o_next;
    logic [6:0]  idx1_reg;
    logic [8:0]  head1_reg, trail1_reg;
    logic [8:0]  tilt1_reg, tilt_next;
    carry_t      c1_reg, c1_next;
    logic signed [11:0] tilt_off;
    logic [10:0] tilt_pos;

    always_comb
    begin
        prod_a_next = 16'({9'b0, vertex_index} * {7'b0, trail_span});
        prod_o_next = 15'({8'b0, vertex_index} * {7'b0, ring_opacity});
        tilt_off    = 12'(tilt_degrees) + 12'sd720;
        tilt_pos    = tilt_off[10:0];
        priority if (tilt_pos >= 11'd1080)
            tilt_next = 9'(tilt_pos - 11'd1080);
        else if (tilt_pos >= 11'd720)
            tilt_next = 9'(tilt_pos - 11'd720);
        else if (tilt_pos >= 11'd360)
            tilt_next = 9'(tilt_pos - 11'd360);
        else
            tilt_next = 9'(tilt_pos);
        c1_next = '{center_x: center_x, center_y: center_y,
                    radius_x: radius_x, radius_y: radius_y,
                    start_color: start_color, end_color: end_color,
                    lerp_t: '0, opacity: '0,
                    path_start: (vertex_index == 7'd0),
                    visible: (ring_opacity >= 8'd2)};
    end

    // Stage 2: reciprocal estimates
    logic        v2_reg;
    logic [15:0] prod_a2_reg;
    logic [14:0] prod_o2_reg;
    logic [6:0]  idx2_reg;
    logic [8:0]  head2_reg, trail2_reg, tilt2_reg;
    logic [16:0] qe_a2_reg, qe_a_next;
    logic [15:0] qe_o2_reg, qe_o_next;
    logic [22:0] qe_t2_reg, qe_t_next;
    carry_t      c2_reg;
    logic [40:0] mul_a;
    logic [39:0] mul_o;
    logic [30:0] mul_t;

    always_comb
    begin
        mul_a     = {25'b0, prod_a1_reg} * {16'b0, RECIP};
        mul_o     = {25'b0, prod_o1_reg} * {15'b0, RECIP};
        mul_t     = {24'b0, idx1_reg} * {6'b0, RECIP};
        qe_a_next = mul_a[40:24];
        qe_o_next = mul_o[39:24];
        qe_t_next = mul_t[30:8];
    end

    // Stage 3: correct the estimates, form the offset vertex angle
    logic        v3_reg;
    logic [16:0] deg3_reg, deg_next;
    logic [8:0]  tilt3_reg;
    carry_t      c3_reg, c3_next;
    logic [31:0] rem_a, rem_o, rem_t;
    logic [16:0] q_a;
    logic [15:0] q_o;
    logic [22:0] q_t;
    logic [17:0] deg_sum;

    always_comb
    begin
        rem_a = {16'b0, prod_a2_reg} - ({15'b0, qe_a2_reg} * {24'b0, STEPS_C});
        rem_o = {17'b0, prod_o2_reg} - ({16'b0, qe_o2_reg} * {24'b0, STEPS_C});
        rem_t = {9'b0, idx2_reg, 16'b0} - ({9'b0, qe_t2_reg} * {24'b0, STEPS_C});
        q_a   = (rem_a >= {24'b0, STEPS_C}) ? qe_a2_reg + 17'd1 : qe_a2_reg;
        q_o   = (rem_o >= {24'b0, STEPS_C}) ? qe_o2_reg + 16'd1 : qe_o2_reg;
        q_t   = (rem_t >= {24'b0, STEPS_C}) ? qe_t2_reg + 23'd1 : qe_t2_reg;
        deg_sum  = {9'b0, head2_reg} + 18'(ANGLE_OFFSET) - {9'b0, trail2_reg}
                 + {1'b0, q_a};
        deg_next = deg_sum[16:0];
        c3_next         = c2_reg;
        c3_next.lerp_t  = q_t;
        c3_next.opacity = q_o[7:0];
    end

    // Stage 4: quotient estimate of the angle by a full turn
    logic        v4_reg;
    logic [16:0] deg4_reg;
    logic [8:0]  dq4_reg, dq_next;
    logic [8:0]  tilt4_reg;
    carry_t      c4_reg;
    logic [32:0] mul_d;

    always_comb
    begin
        mul_d   = {16'b0, deg3_reg} * {17'b0, 16'(RECIP_360)};
        dq_next = mul_d[32:24];
    end

    // Stage 5: remainder and final wrap
    logic        v5_reg;
    logic [8:0]  w5_reg, w_next;
    logic [8:0]  tilt5_reg;
    carry_t      c5_reg;
    logic [16:0] rem_d;

    always_comb
    begin
        rem_d  = deg4_reg - 17'({8'b0, dq4_reg} * 17'(FULL_TURN));
        w_next = (rem_d >= 17'(FULL_TURN)) ? 9'(rem_d - 17'(FULL_TURN)) : 9'(rem_d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a1_reg <= prod_a_next;
            prod_o1_reg <= prod_o_next;
            idx1_reg    <= vertex_index;
            head1_reg   <= head_angle;
            trail1_reg  <= trail_span;
            tilt1_reg   <= tilt_next;
            c1_reg      <= c1_next;

            prod_a2_reg <= prod_a1_reg;
            prod_o2_reg <= prod_o1_reg;
            idx2_reg    <= idx1_reg;
            head2_reg   <= head1_reg;
            trail2_reg  <= trail1_reg;
            tilt2_reg   <= tilt1_reg;
            qe_a2_reg   <= qe_a_next;
            qe_o2_reg   <= qe_o_next;
            qe_t2_reg   <= qe_t_next;
            c2_reg      <= c1_reg;

            deg3_reg    <= deg_next;
            tilt3_reg   <= tilt2_reg;
            c3_reg      <= c3_next;

            deg4_reg    <= deg3_reg;
            dq4_reg     <= dq_next;
            tilt4_reg   <= tilt3_reg;
            c4_reg      <= c3_reg;

            w5_reg      <= w_next;
            tilt5_reg   <= tilt4_reg;
            c5_reg      <= c4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign out_w_deg  = w5_reg;
    assign out_w_tilt = tilt5_reg;
    assign out_carry  = c5_reg;

endmodule

[design/tea_sincos.sv]
// ----------------------------------------------------------------------------
// tea_sincos
// Bhaskara I sine for four angles in parallel: one setup stage, then a
// restoring divider spread over three stages.
// ----------------------------------------------------------------------------
module tea_sincos (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [8:0]      w_deg,
    input  logic [8:0]      w_tilt,
    input  tea_pkg::carry_t in_carry,
    output logic            out_valid,
    output tea_pkg::trig_t  out_trig,
    output tea_pkg::carry_t out_carry
);
    import tea_pkg::*;

    localparam int NCH = 4;

    logic va_reg, vb_reg, vc_reg, vd_reg;
    carry_t ca_reg, cb_reg, cc_reg, cd_reg;
    logic signed [17:0] val_reg [NCH];

    for (genvar ch = 0; ch < NCH; ch++)
    begin : g_ch
        logic [8:0]  ang;
        logic [9:0]  ang_sh;
        logic [8:0]  ang_w;
        logic [7:0]  e;
        logic        neg_next;
        logic [12:0] p_next;
        logic [12:0] pa_reg;
        logic        nega_reg, negb_reg, negc_reg;
        logic [31:0] remb_reg, remc_reg, remb_next, remc_next, remd;
        logic [16:0] qb_reg, qc_reg, qb_next, qc_next, qd;
        logic [15:0] db_reg, dc_reg, d_next;
        logic signed [17:0] val_next;

        // Even channels take the sine, odd the cosine (angle plus a quarter)
        always_comb
        begin
            ang    = (ch >= 2) ? w_tilt : w_deg;
            ang_sh = {1'b0, ang} + (((ch % 2) == 1) ? 10'(QUARTER_TURN) : 10'd0);
            ang_w  = (ang_sh >= 10'(FULL_TURN)) ? 9'(ang_sh - 10'(FULL_TURN))
                                                : ang_sh[8:0];
            neg_next = (ang_w >= 9'(HALF_TURN));
            e        = neg_next ? 8'(ang_w - 9'(HALF_TURN)) : ang_w[7:0];
            p_next   = 13'({5'b0, e} * (13'(HALF_TURN) - {5'b0, e}));
        end

        // Quotient bits 16 down to 11
        always_comb
        begin
            d_next    = 16'(BHASKARA_K) - {3'b0, pa_reg};
            remb_next = {1'b0, pa_reg, 18'b0};
            qb_next   = '0;
            for (int i = 16; i >= 11; i--)
            begin
                if (remb_next >= ({16'b0, d_next} << i))
                begin
                    remb_next  = remb_next - ({16'b0, d_next} << i);
                    qb_next[i] = 1'b1;
                end
            end
        end

        // Quotient bits 10 down to 5
        always_comb
        begin
            remc_next = remb_reg;
            qc_next   = qb_reg;
            for (int i = 10; i >= 5; i--)
            begin
                if (remc_next >= ({16'b0, db_reg} << i))
                begin
                    remc_next  = remc_next - ({16'b0, db_reg} << i);
                    qc_next[i] = 1'b1;
                end
            end
        end

        // Quotient bits 4 down to 0, then apply the half-turn sign
        always_comb
        begin
            remd = remc_reg;
            qd   = qc_reg;
            for (int i = 4; i >= 0; i--)
            begin
                if (remd >= ({16'b0, dc_reg} << i))
                begin
                    remd  = remd - ({16'b0, dc_reg} << i);
                    qd[i] = 1'b1;
                end
            end
            val_next = negc_reg ? -$signed({1'b0, qd}) : $signed({1'b0, qd});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg      <= p_next;
                nega_reg    <= neg_next;
                remb_reg    <= remb_next;
                qb_reg      <= qb_next;
                db_reg      <= d_next;
                negb_reg    <= nega_reg;
                remc_reg    <= remc_next;
                qc_reg      <= qc_next;
                dc_reg      <= db_reg;
                negc_reg    <= negb_reg;
                val_reg[ch] <= val_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg <= in_carry;
            cb_reg <= ca_reg;
            cc_reg <= cb_reg;
            cd_reg <= cc_reg;
        end
    end

    assign out_valid         = vd_reg;
    assign out_trig.sin_deg  = val_reg[0];
    assign out_trig.cos_deg  = val_reg[1];
    assign out_trig.sin_tilt = val_reg[2];
    assign out_trig.cos_tilt = val_reg[3];
    assign out_carry         = cd_reg;

endmodule

[design/tea_rotate.sv]
// ----------------------------------------------------------------------------
// tea_rotate
// Three-stage back end: scale by the radii, rotate by the tilt, offset by
// the centre and floor; colour lerp runs alongside.
// ----------------------------------------------------------------------------
module tea_rotate (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  tea_pkg::trig_t  in_trig,
    input  tea_pkg::carry_t in_carry,
    output logic            out_valid,
    output logic [13:0]     vertex_x,
    output logic [13:0]     vertex_y,
    output logic [23:0]     vertex_color,
    output logic [7:0]      vertex_opacity,
    output logic            path_start,
    output logic            visible
);
    import tea_pkg::*;

    // Stage 1: ellipse point and colour products
    logic v1_reg, v2_reg, v3_reg;
    logic signed [28:0] ex1_reg, ey1_reg, ex_next, ey_next;
    logic signed [17:0] cos_t1_reg, sin_t1_reg;
    logic signed [32:0] cp1_reg [3];
    logic signed [32:0] cp_next [3];
    carry_t c1_reg, c2_reg;

    always_comb
    begin
        ex_next = 29'($signed({1'b0, in_carry.radius_x})) * 29'(in_trig.cos_deg);
        ey_next = 29'($signed({1'b0, in_carry.radius_y})) * 29'(in_trig.sin_deg);
        for (int k = 0; k < 3; k++)
        begin
            cp_next[k] = 33'($signed({1'b0, in_carry.end_color[8*k +: 8]})
                             - $signed({1'b0, in_carry.start_color[8*k +: 8]}))
                       * 33'($signed({1'b0, in_carry.lerp_t}));
        end
    end

    // Stage 2: rotation terms, floored, and colour channels
    logic signed [30:0] xc2_reg, ys2_reg, xs2_reg, yc2_reg;
    logic signed [30:0] xc_next, ys_next, xs_next, yc_next;
    logic signed [46:0] m_xc, m_ys, m_xs, m_yc;
    logic [23:0] col2_reg, col_next;
    logic signed [32:0] cv;

    always_comb
    begin
        m_xc    = 47'(ex1_reg) * 47'(cos_t1_reg);
        m_ys    = 47'(ey1_reg) * 47'(sin_t1_reg);
        m_xs    = 47'(ex1_reg) * 47'(sin_t1_reg);
        m_yc    = 47'(ey1_reg) * 47'(cos_t1_reg);
        xc_next = m_xc[46:16];
        ys_next = m_ys[46:16];
        xs_next = m_xs[46:16];
        yc_next = m_yc[46:16];
        col_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            cv = $signed({9'b0, c1_reg.start_color[8*k +: 8], 16'b0}) + cp1_reg[k];
            col_next[8*k +: 8] = cv[23:16];
        end
    end

    // Stage 3: add the centre, floor to pixels
    logic [13:0] x3_reg, y3_reg, x_next, y_next;
    logic [23:0] col3_reg;
    logic [7:0]  op3_reg;
    logic        ps3_reg, vis3_reg;
    logic signed [31:0] px, py;

    always_comb
    begin
        px = $signed({4'b0, c2_reg.center_x, 16'b0}) + 32'(xc2_reg) - 32'(ys2_reg);
        py = $signed({4'b0, c2_reg.center_y, 16'b0}) + 32'(xs2_reg) + 32'(yc2_reg);
        x_next = px[29:16];
        y_next = py[29:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex1_reg    <= ex_next;
            ey1_reg    <= ey_next;
            cos_t1_reg <= in_trig.cos_tilt;
            sin_t1_reg <= in_trig.sin_tilt;
            cp1_reg    <= cp_next;
            c1_reg     <= in_carry;

            xc2_reg    <= xc_next;
            ys2_reg    <= ys_next;
            xs2_reg    <= xs_next;
            yc2_reg    <= yc_next;
            col2_reg   <= col_next;
            c2_reg     <= c1_reg;

            x3_reg     <= x_next;
            y3_reg     <= y_next;
            col3_reg   <= col2_reg;
            op3_reg    <= c2_reg.opacity;
            ps3_reg    <= c2_reg.path_start;
            vis3_reg   <= c2_reg.visible;
        end
    end

    assign out_valid      = v3_reg;
    assign vertex_x       = x3_reg;
    assign vertex_y       = y3_reg;
    assign vertex_color   = col3_reg;
    assign vertex_opacity = op3_reg;
    assign path_start     = ps3_reg;
    assign visible        = vis3_reg;

endmodule

[design/tilted_ellipse_arc_vertex_top.sv]
// ----------------------------------------------------------------------------
// tilted_ellipse_arc_vertex_top
// Computes one vertex of a tilted, glowing elliptical arc per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with one port per request field. A
//   transaction is taken at a rising edge with in_valid high, in_stall low.
//   Output channel: out_valid / out_stall with one port per result field.
//   Every input transaction yields exactly one output transaction, in order.
//   Stages: 5 angle, 4 sine and 3 rotate stages from acceptance to out_valid.
//   Throughput: one vertex per cycle while out_stall does not hold the
//   pipeline; the restoring divider of the sine unit is spread over three
//   stages, so no unit is shared between vertices.
//   Stall: while a result sits in the output register and out_stall is high,
//   the whole pipeline holds and in_stall is raised; no transaction is lost
//   or repeated. in_stall depends combinationally on out_stall.
//   Reset: rst_n clears all stage valid bits; payload registers are not
//   cleared. No clearing pass is needed; the block accepts on the first
//   cycle after reset.
// ----------------------------------------------------------------------------
module tilted_ellipse_arc_vertex_top #(
    parameter int STEPS = 90
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [11:0]       center_x,
    input  logic [11:0]       center_y,
    input  logic [9:0]        radius_x,
    input  logic [9:0]        radius_y,
    input  logic signed [9:0] tilt_degrees,
    input  logic [8:0]        head_angle,
    input  logic [8:0]        trail_span,
    input  logic [7:0]        ring_opacity,
    input  logic [6:0]        vertex_index,
    input  logic [23:0]       start_color,
    input  logic [23:0]       end_color,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [13:0] vertex_x,
    output logic signed [13:0] vertex_y,
    output logic [23:0]       vertex_color,
    output logic [7:0]        vertex_opacity,
    output logic              path_start,
    output logic              visible
);
    import tea_pkg::*;

    logic   en;
    logic   ang_valid, sc_valid;
    logic [8:0] w_deg, w_tilt;
    carry_t ang_carry, sc_carry;
    trig_t  trig;
    logic [13:0] x_u, y_u;

    // Advance every stage unless the output register holds an untaken result
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    tea_angle #(
        .STEPS(STEPS)
    ) u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius_x    (radius_x),
        .radius_y    (radius_y),
        .tilt_degrees(tilt_degrees),
        .head_angle  (head_angle),
        .trail_span  (trail_span),
        .ring_opacity(ring_opacity),
        .vertex_index(vertex_index),
        .start_color (start_color),
        .end_color   (end_color),
        .out_valid   (ang_valid),
        .out_w_deg   (w_deg),
        .out_w_tilt  (w_tilt),
        .out_carry   (ang_carry)
    );

    tea_sincos u_sincos (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (ang_valid),
        .w_deg    (w_deg),
        .w_tilt   (w_tilt),
        .in_carry (ang_carry),
        .out_valid(sc_valid),
        .out_trig (trig),
        .out_carry(sc_carry)
    );

    tea_rotate u_rotate (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (sc_valid),
        .in_trig       (trig),
        .in_carry      (sc_carry),
        .out_valid     (out_valid),
        .vertex_x      (x_u),
        .vertex_y      (y_u),
        .vertex_color  (vertex_color),
        .vertex_opacity(vertex_opacity),
        .path_start    (path_start),
        .visible       (visible)
    );

    assign vertex_x = $signed(x_u);
    assign vertex_y = $signed(y_u);

    // The tail vertex always carries zero opacity
    a_start_opacity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_start |-> vertex_opacity == 8'd0)
        else $error("tail vertex with non-zero opacity");

    // Bhaskara magnitudes never exceed one in signed Q1.16
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid |-> trig.cos_deg <= 18'sd65536 && trig.cos_deg >= -18'sd65536)
        else $error("vertex cosine out of range");

    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid |-> trig.sin_tilt <= 18'sd65536 && trig.sin_tilt >= -18'sd65536)
        else $error("tilt sine out of range");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for tilted_ellipse_arc_vertex_top: drives directed and random
// vertex requests with random idling and stalls, predicts every vertex in
// Q16.16 and checks each output transaction in order.
// ----------------------------------------------------------------------------

// Vertex request fields
typedef struct {
    logic [11:0]       cx;
    logic [11:0]       cy;
    logic [9:0]        rx;
    logic [9:0]        ry;
    logic signed [9:0] tilt;
    logic [8:0]        head;
    logic [8:0]        trail;
    logic [7:0]        opac;
    logic [6:0]        idx;
    logic [23:0]       c0;
    logic [23:0]       c1;
} vtx_req_t;

// Vertex result fields
typedef struct {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic [23:0]        color;
    logic [7:0]         opac;
    logic               first;
    logic               vis;
} vtx_res_t;

class vertex_scoreboard;
    vtx_res_t pending[$];
    int       errors = 0;

    // Floor division of a Q32.32 product back to Q16.16
    static function longint fl16(longint v);
        return v >>> 16;
    endfunction

    static function longint sine_q16(longint d);
        longint w;
        longint e;
        longint p;
        longint m;
        w = ((d % 360) + 360) % 360;
        e = w % 180;
        p = e * (180 - e);
        m = (4 * p * 65536) / (40500 - p);
        return (w >= 180) ? -m : m;
    endfunction

    static function logic [7:0] blend(longint a, longint b, longint t);
        longint v;
        v = a * 65536 + fl16((b - a) * 65536 * t);
        return 8'(fl16(v));
    endfunction

    function void note_request(vtx_req_t r, int steps);
        vtx_res_t o;
        longint deg;
        longint ct;
        longint st;
        longint ex;
        longint ey;
        longint t;
        deg = longint'(r.head) - longint'(r.trail)
              + (longint'(r.idx) * longint'(r.trail)) / steps;
        ct = sine_q16(longint'(r.tilt) + 90);
        st = sine_q16(longint'(r.tilt));
        ex = fl16(longint'(r.rx) * 65536 * sine_q16(deg + 90));
        ey = fl16(longint'(r.ry) * 65536 * sine_q16(deg));
        o.x = 14'(fl16(longint'(r.cx) * 65536 + fl16(ex * ct) - fl16(ey * st)));
        o.y = 14'(fl16(longint'(r.cy) * 65536 + fl16(ex * st) + fl16(ey * ct)));
        t = (longint'(r.idx) * 65536) / steps;
        o.color = {blend(longint'(r.c0[23:16]), longint'(r.c1[23:16]), t),
                   blend(longint'(r.c0[15:8]), longint'(r.c1[15:8]), t),
                   blend(longint'(r.c0[7:0]), longint'(r.c1[7:0]), t)};
        o.opac  = 8'((longint'(r.idx) * longint'(r.opac)) / steps);
        o.first = (r.idx == 0);
        o.vis   = (r.opac >= 2);
        pending.push_back(o);
    endfunction

    function void check_result(vtx_res_t a);
        vtx_res_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected vertex x=%0d y=%0d", a.x, a.y);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.x !== e.x) begin $error("vertex_x exp %0d got %0d", e.x, a.x); errors++; end
        if (a.y !== e.y) begin $error("vertex_y exp %0d got %0d", e.y, a.y); errors++; end
        if (a.color !== e.color)
        begin
            $error("vertex_color exp %06h got %06h", e.color, a.color);
            errors++;
        end
        if (a.opac !== e.opac)
        begin
            $error("vertex_opacity exp %0d got %0d", e.opac, a.opac);
            errors++;
        end
        if (a.first !== e.first)
        begin
            $error("path_start exp %0b got %0b", e.first, a.first);
            errors++;
        end
        if (a.vis !== e.vis) begin $error("visible exp %0b got %0b", e.vis, a.vis); errors++; end
    endfunction
endclass

module tb;
    localparam int STEPS     = 90;
    localparam int LATENCY   = 12;
    localparam int N_RANDOM  = 800;
    localparam int MAX_CYCLE = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [9:0] radius_x;
    logic [9:0] radius_y;
    logic signed [9:0] tilt_degrees;
    logic [8:0] head_angle;
    logic [8:0] trail_span;
    logic [7:0] ring_opacity;
    logic [6:0] vertex_index;
    logic [23:0] start_color;
    logic [23:0] end_color;
    logic out_valid;
    logic out_stall;
    logic signed [13:0] vertex_x;
    logic signed [13:0] vertex_y;
    logic [23:0] vertex_color;
    logic [7:0] vertex_opacity;
    logic path_start;
    logic visible;

    vertex_scoreboard vertex_sb = new();
    int  cycle_count = 0;
    int  n_sent = 0;
    bit  calm = 0;        // both sides run without idling in this stretch
    bit  hold_off = 0;    // receiver holds off for a long stretch
    vtx_req_t directed[$];

    tilted_ellipse_arc_vertex_top #(.STEPS(STEPS)) dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Receiver: stall at random, never while calm, always during hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (!calm && $urandom_range(99) < 36);
    end

    // Compare every output transaction as it is taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            vertex_sb.check_result('{vertex_x, vertex_y, vertex_color, vertex_opacity,
                                     path_start, visible});
        cycle_count++;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic vtx_req_t random_request();
        vtx_req_t r;
        r.cx = 12'($urandom); r.cy = 12'($urandom);
        r.rx = 10'($urandom); r.ry = 10'($urandom);
        r.tilt = 10'($urandom_range(720) - 360);
        r.head = 9'($urandom_range(359));
        r.trail = 9'($urandom_range(360));
        r.opac = 8'($urandom);
        r.idx = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(STEPS));
        r.c0 = 24'($urandom); r.c1 = 24'($urandom);
        // Now and then reach the full width of the fields
        if ($urandom_range(19) == 0)
        begin
            r.tilt = 10'($urandom); r.head = 9'($urandom); r.trail = 9'($urandom);
        end
        return r;
    endfunction

    // Offer one transaction and hold it until taken
    task automatic send_request(vtx_req_t r);
        while (!calm && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        center_x <= r.cx; center_y <= r.cy;
        radius_x <= r.rx; radius_y <= r.ry;
        tilt_degrees <= r.tilt; head_angle <= r.head;
        trail_span <= r.trail; ring_opacity <= r.opac;
        vertex_index <= r.idx;
        start_color <= r.c0; end_color <= r.c1;
        do
            @(posedge clk);
        while (in_stall);
        vertex_sb.note_request(r, STEPS);
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (vertex_sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Long receiver hold-off in its own process while the sender keeps offering
    initial
    begin
        wait (n_sent >= 150);
        @(posedge clk);
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        vtx_req_t r;
        rst_n = 0;
        in_valid = 0;
        center_x = 0; center_y = 0; radius_x = 0; radius_y = 0;
        tilt_degrees = 0; head_angle = 0; trail_span = 0; ring_opacity = 0;
        vertex_index = 0; start_color = 0; end_color = 0;
        repeat (6) @(posedge clk);
        rst_n = 1;

        // Directed: field extremes, first vertex, index past STEPS, negative tilt
        r = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};               directed.push_back(r);
        r = '{4095, 4095, 1023, 1023, 360, 359, 360, 255, 90,
              24'hFFFFFF, 24'h000000};                        directed.push_back(r);
        r = '{0, 0, 1023, 1023, -360, 0, 360, 1, 127,
              24'h000000, 24'hFFFFFF};                        directed.push_back(r);
        r = '{2048, 2048, 500, 300, -45, 90, 180, 2, 45,
              24'h123456, 24'hABCDEF};                        directed.push_back(r);
        r = '{100, 4000, 1023, 0, -1, 180, 0, 255, 0,
              24'hFF00FF, 24'h00FF00};                        directed.push_back(r);
        r = '{4000, 100, 0, 1023, 511, 511, 511, 128, 100,
              24'h808080, 24'h7F7F7F};                        directed.push_back(r);
        r = '{0, 4095, 700, 700, -512, 270, 1, 3, 1,
              24'h0000FF, 24'hFF0000};                        directed.push_back(r);
        r = '{1, 1, 1, 1, 90, 359, 359, 254, 89,
              24'hFFFFFF, 24'hFFFFFF};                        directed.push_back(r);
        foreach (directed[i])
            send_request(directed[i]);

        // Sender pause until every vertex has come out
        drain();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 300 && n < 400);
            send_request(random_request());
        end
        calm = 0;
        drain();
        repeat (LATENCY * 3) @(posedge clk);

        if (vertex_sb.errors == 0 && vertex_sb.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
